/* sv/fpr_pkg.sv */
`timescale 1ns / 1ps
package fpr_pkg;
   localparam int unsigned WordWidth = 64;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth = 11;
   typedef enum logic [1:0] {
      CSR_MANTISSA_BITS = 2'd0,
      CSR_MIN_EXPONENT  = 2'd1,
      CSR_MAX_EXPONENT  = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;
endpackage

/* sv/float_precision_round_rne.sv */
`timescale 1ns / 1ps
// Rounds each IEEE double to a narrower binary format (precision, least normal
// exponent and greatest exponent set through the csr_ port; reset gives half
// precision), round to nearest even, result again a double. Zero, NaN and
// infinity pass unchanged; overflow gives signed infinity, underflow signed
// zero. Four register stages (decode, shift, round, pack): one beat enters
// every cycle while req_stall is low and leaves from the pack register.
// rsp_stall freezes the whole pipeline while rsp_valid is high; req_stall follows it.
module float_precision_round_rne (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [63:0]                          req_value_bits,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [63:0]                          rsp_rounded_bits,
   input  logic                                 csr_write,
   input  logic [fpr_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [fpr_pkg::CsrDataWidth-1:0]     csr_data
);
   logic [5:0]         mant_bits_ff;
   logic signed [10:0] min_exp_ff;
   logic [9:0]         max_exp_ff;

   logic advance;
   assign advance = !rsp_stall || !rsp_valid;
   assign req_stall = !advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mant_bits_ff <= 6'd11;
         min_exp_ff   <= -11'sd14;
         max_exp_ff   <= 10'd15;
      end else if (csr_write) begin
         unique case (fpr_pkg::csr_index_type'(csr_index))
            fpr_pkg::CSR_MANTISSA_BITS: mant_bits_ff <= csr_data[5:0];
            fpr_pkg::CSR_MIN_EXPONENT:  min_exp_ff <= $signed(csr_data);
            fpr_pkg::CSR_MAX_EXPONENT:  max_exp_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // stage 1: decode, find top bit, compute shift
   logic        pass1_in;
   logic        sign1_in;
   logic [52:0] sig1_in;
   logic signed [12:0] lsb1_in, e1_in, q1_in;
   logic [5:0]  top1;
   always_comb begin
      sign1_in = req_value_bits[63];
      pass1_in = (req_value_bits[62:52] == 11'h7FF) || (req_value_bits[62:0] == 63'd0);
      if (req_value_bits[62:52] == 11'd0) begin
         sig1_in = {1'b0, req_value_bits[51:0]};
         lsb1_in = -13'sd1074;
      end else begin
         sig1_in = {1'b1, req_value_bits[51:0]};
         lsb1_in = $signed({2'b00, req_value_bits[62:52]}) - 13'sd1075;
      end
      top1 = 6'd0;
      for (int i = 0; i < 53; i++) begin
         if (sig1_in[i]) top1 = 6'(i);
      end
      e1_in = lsb1_in + $signed({7'd0, top1});
      q1_in = ((e1_in > 13'(min_exp_ff)) ? e1_in : 13'(min_exp_ff))
              - $signed({7'd0, mant_bits_ff}) + 13'sd1;
   end

   logic        v1_ff, pass1_ff, sign1_ff;
   logic [63:0] raw1_ff;
   logic [52:0] sig1_ff;
   logic signed [12:0] lsb1_ff, q1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         pass1_ff <= pass1_in; sign1_ff <= sign1_in; raw1_ff <= req_value_bits;
         sig1_ff <= sig1_in; lsb1_ff <= lsb1_in; q1_ff <= q1_in;
      end
   end

   // stage 2: shift right, rounding decision
   logic [52:0] kept2_in;
   logic        inc2_in;
   logic signed [12:0] lsb2_in, s2;
   logic [53:0] rem_mask;
   logic [53:0] rem2, half2;
   always_comb begin
      s2 = q1_ff - lsb1_ff;
      kept2_in = sig1_ff;
      inc2_in = 1'b0;
      lsb2_in = lsb1_ff;
      rem_mask = '0; rem2 = '0; half2 = '0;
      if (q1_ff > lsb1_ff) begin
         lsb2_in = q1_ff;
         if (s2 >= 13'sd55) begin
            kept2_in = '0;
         end else begin
            kept2_in = sig1_ff >> s2[5:0];
            rem_mask = (54'd1 << s2[5:0]) - 54'd1;
            rem2 = {1'b0, sig1_ff} & rem_mask;
            half2 = 54'd1 << (s2[5:0] - 6'd1);
            inc2_in = (rem2 > half2) || ((rem2 == half2) && kept2_in[0]);
         end
      end
   end

   logic        v2_ff, pass2_ff, sign2_ff, inc2_ff;
   logic [63:0] raw2_ff;
   logic [52:0] kept2_ff;
   logic signed [12:0] lsb2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         pass2_ff <= pass1_ff; sign2_ff <= sign1_ff; raw2_ff <= raw1_ff;
         kept2_ff <= kept2_in; inc2_ff <= inc2_in; lsb2_ff <= lsb2_in;
      end
   end

   // stage 3: increment, find new top bit
   logic [53:0] sig3_in;
   logic [5:0]  top3;
   always_comb begin
      sig3_in = {1'b0, kept2_ff} + {53'd0, inc2_ff};
      top3 = 6'd0;
      for (int i = 0; i < 54; i++) begin
         if (sig3_in[i]) top3 = 6'(i);
      end
   end

   logic        v3_ff, pass3_ff, sign3_ff;
   logic [63:0] raw3_ff;
   logic [53:0] sig3_ff;
   logic [5:0]  top3_ff;
   logic signed [12:0] lsb3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         pass3_ff <= pass2_ff; sign3_ff <= sign2_ff; raw3_ff <= raw2_ff;
         sig3_ff <= sig3_in; top3_ff <= top3; lsb3_ff <= lsb2_ff;
      end
   end

   // stage 4: overflow check and pack
   logic [63:0] out4_in;
   logic signed [12:0] eout4, sub_sh;
   logic [53:0] norm4;
   always_comb begin
      eout4 = lsb3_ff + $signed({7'd0, top3_ff});
      sub_sh = lsb3_ff + 13'sd1074;
      norm4 = '0;
      if (pass3_ff) begin
         out4_in = raw3_ff;
      end else if (sig3_ff == '0) begin
         out4_in = {sign3_ff, 63'd0};
      end else if (eout4 > $signed({3'd0, max_exp_ff})) begin
         out4_in = {sign3_ff, 11'h7FF, 52'd0};
      end else if (eout4 >= -13'sd1022) begin
         norm4 = sig3_ff << (6'd52 - top3_ff);
         out4_in = {sign3_ff, 11'(eout4 + 13'sd1023), norm4[51:0]};
      end else begin
         norm4 = sig3_ff << sub_sh[5:0];
         out4_in = {sign3_ff, 11'd0, norm4[51:0]};
      end
   end

   logic        v4_ff;
   logic [63:0] out4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) out4_ff <= out4_in;
   end

   assign rsp_valid = v4_ff;
   assign rsp_rounded_bits = out4_ff;
endmodule

/* sv/fpr_checker.sv */
`timescale 1ns / 1ps
module fpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_rounded_bits
);
   // hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rounded_bits))
      else $error("stalled result beat changed");
   // input stall only while output is stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_stall && rsp_valid)
      else $error("input stalled without output stall");
   // accepted beat reaches the output if the output does not stall meanwhile
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("result beat lost");
   // nothing comes out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind float_precision_round_rne fpr_checker u_fpr_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_rounded_bits(rsp_rounded_bits)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
   localparam int IdleLimit = 4000;
   localparam int RandomBeats = 1850;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [63:0] req_value_bits = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [63:0] rsp_rounded_bits;
   logic csr_write = 1'b0;
   fpr_pkg::csr_index_type csr_index = fpr_pkg::CSR_MANTISSA_BITS;
   logic [fpr_pkg::CsrDataWidth-1:0] csr_data = '0;

   // current rounding format
   int unsigned fmt_precision;
   int fmt_emin;
   int fmt_emax;

   logic [63:0] pending_rounded[$];
   int failures = 0;
   int idle_cycles = 0;
   bit quiet_req = 1'b0;
   bit quiet_rsp = 1'b0;

   float_precision_round_rne DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int msb_index(logic [63:0] v);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++) if (v[i]) n = i;
      return n;
   endfunction

   // round one double to the current format, nearest even
   function automatic logic [63:0] round_to_format(logic [63:0] bits);
      logic sign;
      int field;
      logic [63:0] sig, kept, rem, half;
      longint lsb_exp, e, q, s, e_out;
      sign = bits[63];
      field = bits[62:52];
      if (field == 2047) return bits;
      if (field == 0 && bits[51:0] == 0) return bits;
      if (field == 0) begin
         sig = {12'd0, bits[51:0]};
         lsb_exp = -1074;
      end else begin
         sig = {11'd0, 1'b1, bits[51:0]};
         lsb_exp = field - 1075;
      end
      e = lsb_exp + msb_index(sig);
      q = ((e > fmt_emin) ? e : longint'(fmt_emin)) - (longint'(fmt_precision) - 1);
      if (q > lsb_exp) begin
         s = q - lsb_exp;
         if (s >= 55) begin
            sig = '0;
         end else begin
            kept = sig >> s;
            rem = sig & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && kept[0])) kept++;
            sig = kept;
         end
         lsb_exp = q;
      end
      if (sig == 0) return {sign, 63'd0};
      e_out = lsb_exp + msb_index(sig);
      if (e_out > fmt_emax) return {sign, 11'h7FF, 52'd0};
      if (e_out >= -1022) begin
         sig = sig << (52 - msb_index(sig));
         return {sign, 11'(e_out + 1023), sig[51:0]};
      end
      sig = sig << (lsb_exp + 1074);
      return {sign, 11'd0, sig[51:0]};
   endfunction

   // write one register at idle and mirror it
   task automatic write_csr(fpr_pkg::csr_index_type idx,
                            logic [fpr_pkg::CsrDataWidth-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      unique case (idx)
         fpr_pkg::CSR_MANTISSA_BITS: fmt_precision = val[5:0];
         fpr_pkg::CSR_MIN_EXPONENT: fmt_emin = $signed(val);
         fpr_pkg::CSR_MAX_EXPONENT: fmt_emax = val[9:0];
         default: ;
      endcase
   endtask

   task automatic set_format(int p, int emin, int emax);
      write_csr(fpr_pkg::CSR_MANTISSA_BITS, fpr_pkg::CsrDataWidth'(p));
      write_csr(fpr_pkg::CSR_MIN_EXPONENT, fpr_pkg::CsrDataWidth'(emin));
      write_csr(fpr_pkg::CSR_MAX_EXPONENT, fpr_pkg::CsrDataWidth'(emax));
   endtask

   // hand one beat to the block; hold until accepted
   task automatic send_value(logic [63:0] v, bit typed, logic [63:0] want);
      while (!quiet_req && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value_bits <= v;
      pending_rounded = {pending_rounded, (typed ? want : round_to_format(v))};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rounded.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [63:0] random_double();
      logic [63:0] v;
      int unsigned exp_pick;
      v = {$urandom, $urandom};
      exp_pick = $urandom_range(99);
      // bias exponents toward the target range and its edges
      if (exp_pick < 60) v[62:52] = 11'(1023 + $signed($urandom_range(70)) - 40);
      else if (exp_pick < 70) v[62:52] = 11'd0;
      else if (exp_pick < 75) v[62:52] = 11'h7FF;
      else if (exp_pick < 80) v[51:0] = $urandom_range(1) ? '0 : {52{1'b1}};
      return v;
   endfunction

   // response side: random stall and check each beat
   always @(posedge clock) begin
      logic [63:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rounded.size() == 0) begin
               $error("unexpected beat rounded_bits=%h", rsp_rounded_bits);
               failures++;
            end else begin
               want = pending_rounded.pop_front();
               if (rsp_rounded_bits !== want) begin
                  $error("rounded_bits expected %h actual %h", want, rsp_rounded_bits);
                  failures++;
               end
            end
         end
         rsp_stall <= !quiet_rsp && ($urandom_range(99) < 28);
      end
   end

   // watchdog on accepted beats
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IdleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   typedef struct {
      logic [63:0] value;
      bit typed;
      logic [63:0] want;
   } directed_row_type;

   directed_row_type directed_rows[22] = '{
      '{64'h0000000000000000, 1, 64'h0000000000000000},
      '{64'h8000000000000000, 1, 64'h8000000000000000},
      '{64'h7FF0000000000000, 1, 64'h7FF0000000000000},
      '{64'hFFF0000000000000, 1, 64'hFFF0000000000000},
      '{64'h7FF8000000000001, 1, 64'h7FF8000000000001},
      '{64'hFFFFFFFFFFFFFFFF, 1, 64'hFFFFFFFFFFFFFFFF},
      '{64'h3FF0000000000000, 1, 64'h3FF0000000000000},
      '{64'h40EFFE0000000000, 1, 64'h7FF0000000000000},
      '{64'h40F0000000000000, 1, 64'h7FF0000000000000},
      '{64'h7FEFFFFFFFFFFFFF, 1, 64'h7FF0000000000000},
      '{64'hC0F0000000000000, 1, 64'hFFF0000000000000},
      '{64'h3E70000000000000, 1, 64'h3E70000000000000},
      '{64'h3E60000000000000, 1, 64'h0000000000000000},
      '{64'hBE60000000000000, 1, 64'h8000000000000000},
      '{64'h3E68000000000000, 0, '0},
      '{64'h0000000000000001, 1, 64'h0000000000000000},
      '{64'h000FFFFFFFFFFFFF, 1, 64'h0000000000000000},
      '{64'h3FF0020000000000, 0, '0},
      '{64'h3FF0060000000000, 0, '0},
      '{64'h3FF0030000000000, 0, '0},
      '{64'h3F10000000000000, 0, '0},
      '{64'h3FF5555555555555, 0, '0}
   };

   initial begin
      fmt_precision = 11;
      fmt_emin = -14;
      fmt_emax = 15;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed beats at reset format
      foreach (directed_rows[i])
         send_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
      drain();

      // random phases across formats, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         unique case (phase)
            0: set_format(11, -14, 15);
            1: set_format(24, -126, 127);
            2: set_format(2, -1, 1);
            3: set_format(52, -1021, 1023);
            4: set_format(53 + $urandom_range(10), -1022 - $urandom_range(1), 1023);
            default: set_format($urandom_range(2, 52), -$urandom_range(1, 1021),
                                $urandom_range(1, 1023));
         endcase
         quiet_req = (phase == 1);
         quiet_rsp = (phase == 1);
         for (int n = 0; n < RandomBeats / 6; n++) send_value(random_double(), 0, '0);
         drain();
      end
      quiet_req = 1'b0;
      quiet_rsp = 1'b0;

      if (failures == 0 && pending_rounded.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
